>>> design/nested_token_stream_decoder_assert.svh
// Assertion macros used by the port-level checker.
`ifndef NESTED_TOKEN_STREAM_DECODER_ASSERT_SVH
`define NESTED_TOKEN_STREAM_DECODER_ASSERT_SVH
// Implication checked every clock, quiet during reset.
`define NTSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication, quiet during reset.
`define NTSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

>>> design/ntsd_pkg.sv
// Package with shared constants and types of the token stream decoder.
package ntsd_pkg;
  localparam int MaxDepthDefault = 32;
  localparam int LenW = 20;

  localparam logic [3:0] K_LISTSTART = 4'd0;
  localparam logic [3:0] K_INT       = 4'd1;
  localparam logic [3:0] K_NEGINT    = 4'd2;
  localparam logic [3:0] K_LONGINT   = 4'd3;
  localparam logic [3:0] K_LONGNEG   = 4'd4;
  localparam logic [3:0] K_STRSTART  = 4'd5;
  localparam logic [3:0] K_STRBYTE   = 4'd6;
  localparam logic [3:0] K_VOCAB     = 4'd7;
  localparam logic [3:0] K_FLOAT     = 4'd8;
  localparam logic [3:0] K_LISTEND   = 4'd9;
  localparam logic [3:0] K_ERROR     = 4'd10;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_PREFIX  = 3'd1;
  localparam logic [2:0] E_LIST    = 3'd2;
  localparam logic [2:0] E_STRING  = 3'd3;
  localparam logic [2:0] E_VOCAB   = 3'd4;
  localparam logic [2:0] E_TYPE    = 3'd5;
  localparam logic [2:0] E_DEEP    = 3'd6;

  localparam logic [7:0] T_LIST    = 8'h80;
  localparam logic [7:0] T_INT     = 8'h81;
  localparam logic [7:0] T_STRING  = 8'h82;
  localparam logic [7:0] T_NEG     = 8'h83;
  localparam logic [7:0] T_FLOAT   = 8'h84;
  localparam logic [7:0] T_LONGINT = 8'h85;
  localparam logic [7:0] T_LONGNEG = 8'h86;
  localparam logic [7:0] T_VOCAB   = 8'h87;

  localparam logic [1:0] A_MAXPFX = 2'd0;
  localparam logic [1:0] A_MAXLEN = 2'd1;
  localparam logic [1:0] A_VOCAB  = 2'd2;

  // Command from the decoder to the count stack chain.
  typedef struct packed {
    logic push;       // open a list with count
    logic complete;   // one element finished; may close the top list
    logic [LenW-1:0] count;
  } stk_cmd_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        ovf;
    logic [5:0]  depth;
    logic [2:0]  err;
  } tok_t;
endpackage

>>> design/ntsd_cell.sv
// One cell of the count stack: holds one open list count and shifts with neighbors.
module ntsd_cell (
  input  logic clk,
  input  logic push,
  input  logic pop,
  input  logic dec,
  input  logic [ntsd_pkg::LenW-1:0] from_below,
  input  logic [ntsd_pkg::LenW-1:0] from_above,
  output logic [ntsd_pkg::LenW-1:0] count
);
  // Shift down on push, up on pop, count down on the top cell.
  always_ff @(posedge clk) begin
    if (push) begin
      count <= from_below;
    end else if (pop) begin
      count <= from_above;
    end else if (dec) begin
      count <= count - ntsd_pkg::LenW'(1);
    end
  end
endmodule

>>> design/ntsd_stack.sv
// Count stack built as a chain of cells; cell 0 is the top of stack.
module ntsd_stack #(
  parameter int MAX_DEPTH = ntsd_pkg::MaxDepthDefault,
  parameter int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  ntsd_pkg::stk_cmd_t cmd,
  output logic top_one,           // a finished element now closes the top list
  output logic [DW-1:0] depth
);
  logic [ntsd_pkg::LenW-1:0] cnt [MAX_DEPTH];
  logic dec_top, pop;

  assign top_one = (depth != '0) && (cnt[0] == ntsd_pkg::LenW'(1));
  assign dec_top = cmd.complete && (depth != '0);
  assign pop = dec_top && top_one;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic [ntsd_pkg::LenW-1:0] below, above;
    if (i == 0) begin : g_top
      assign below = cmd.count;
    end else begin : g_mid
      assign below = cnt[i-1];
    end
    if (i == MAX_DEPTH - 1) begin : g_bot
      assign above = cnt[i];
    end else begin : g_up
      assign above = cnt[i+1];
    end
    ntsd_cell u_cell (
      .clk(clk), .push(cmd.push), .pop(pop), .dec(dec_top && (i == 0)),
      .from_below(below), .from_above(above), .count(cnt[i])
    );
  end

  // Track the number of open lists.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push) begin
      depth <= depth + DW'(1);
    end else if (pop) begin
      depth <= depth - DW'(1);
    end
  end
endmodule

>>> design/nested_token_stream_decoder.sv
// Top level of the nested token stream decoder.
// Takes one byte per request on s_axis and emits tokens on m_axis through a
// single output register. A byte is taken only when that register is empty
// or being drained and no list end of the previous byte is still owed; its
// first token is loaded at the same edge. Each list that the byte closes
// adds one list end token after it, since the count stack is a chain of
// cells that pops one entry per cycle while the output register is free;
// an empty list counts as one close. The receiver holding off delays this.
// After an error the block swallows all bytes until reset. Registers at
// paddr 0, 4 and 8.
module nested_token_stream_decoder #(
  parameter int MAX_DEPTH = ntsd_pkg::MaxDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [3:0] kind, [67:4] value, [68] overflow,
                                     // [74:69] depth, [77:75] error code, zeros
  output logic m_axis_tlast          // last_of_run
);
  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    S_PREFIX = 4'b0001, S_STRING = 4'b0010, S_FLOAT = 4'b0100, S_ERROR = 4'b1000
  } mode_t;

  logic [6:0]  max_prefix_bytes;
  logic [19:0] max_length;
  logic [7:0]  vocab_limit;

  mode_t mode;
  logic [63:0] prefix_value;
  logic [6:0]  prefix_count;
  logic        prefix_overflow;
  logic [19:0] payload_left;
  logic [63:0] float_shift;

  ntsd_pkg::stk_cmd_t cmd;
  logic top_one;
  logic [DW-1:0] depth;

  ntsd_pkg::tok_t otok;
  ntsd_pkg::tok_t end_tok;
  logic ovalid, olast;
  logic out_free;
  logic pend;
  logic take;

  logic emit;
  ntsd_pkg::tok_t tok;
  logic complete, pushn, empty_list;
  logic [19:0] pushc;
  logic to_err;
  logic [2:0] ecode;
  logic b_hi;
  logic [6:0] sh7;
  logic [12:0] shift;
  logic [63:0] v64;
  logic deep;

  // Config port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_prefix_bytes <= 7'd64;
      max_length <= 20'd655360;
      vocab_limit <= 8'd31;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ntsd_pkg::A_MAXPFX: max_prefix_bytes <= pwdata[6:0];
        ntsd_pkg::A_MAXLEN: max_length <= pwdata[19:0];
        ntsd_pkg::A_VOCAB:  vocab_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      ntsd_pkg::A_MAXPFX: prdata = {25'd0, max_prefix_bytes};
      ntsd_pkg::A_MAXLEN: prdata = {12'd0, max_length};
      ntsd_pkg::A_VOCAB:  prdata = {24'd0, vocab_limit};
      default: prdata = 32'd0;
    endcase
  end

  ntsd_stack #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_stack (
    .clk(clk), .rst(rst), .cmd(cmd), .top_one(top_one), .depth(depth)
  );

  // Hold the input while the output is full or a list end is still owed.
  assign out_free = !ovalid || m_axis_tready;
  assign s_axis_tready = out_free && !pend;
  assign take = s_axis_tvalid && s_axis_tready;

  // Decode the byte; its first token goes out at once, list ends follow.
  always_comb begin
    b_hi = s_axis_tdata[7];
    emit = 1'b0; complete = 1'b0; pushn = 1'b0; pushc = 20'd0; empty_list = 1'b0;
    to_err = 1'b0; ecode = ntsd_pkg::E_NONE;
    tok = '0;
    tok.depth = 6'(depth);
    v64 = prefix_value;
    deep = (depth >= DW'(MAX_DEPTH));
    sh7 = prefix_count;
    shift = 13'(sh7) * 13'd7;
    case (mode)
      S_PREFIX: begin
        if (!b_hi) begin
          if (prefix_count >= max_prefix_bytes) begin
            to_err = 1'b1; ecode = ntsd_pkg::E_PREFIX;
          end
        end else begin
          case (s_axis_tdata)
            ntsd_pkg::T_LIST: begin
              if (prefix_overflow || v64 > 64'(max_length)) begin
                to_err = 1'b1; ecode = ntsd_pkg::E_LIST;
              end else if (deep) begin
                to_err = 1'b1; ecode = ntsd_pkg::E_DEEP;
              end else begin
                emit = 1'b1; tok.kind = ntsd_pkg::K_LISTSTART; tok.value = v64;
                tok.depth = 6'(depth + DW'(1));
                // An empty list is never pushed; its end is owed instead.
                if (v64 == 64'd0) begin
                  empty_list = 1'b1;
                end else begin
                  pushn = 1'b1; pushc = v64[19:0];
                end
              end
            end
            ntsd_pkg::T_INT, ntsd_pkg::T_NEG, ntsd_pkg::T_LONGINT,
            ntsd_pkg::T_LONGNEG: begin
              emit = 1'b1; tok.value = v64; tok.ovf = prefix_overflow;
              complete = 1'b1;
              case (s_axis_tdata)
                ntsd_pkg::T_INT:     tok.kind = ntsd_pkg::K_INT;
                ntsd_pkg::T_NEG:     tok.kind = ntsd_pkg::K_NEGINT;
                ntsd_pkg::T_LONGINT: tok.kind = ntsd_pkg::K_LONGINT;
                default:             tok.kind = ntsd_pkg::K_LONGNEG;
              endcase
            end
            ntsd_pkg::T_STRING: begin
              if (prefix_overflow || v64 > 64'(max_length)) begin
                to_err = 1'b1; ecode = ntsd_pkg::E_STRING;
              end else begin
                emit = 1'b1; tok.kind = ntsd_pkg::K_STRSTART; tok.value = v64;
                complete = (v64 == 64'd0);
              end
            end
            ntsd_pkg::T_FLOAT: ;
            ntsd_pkg::T_VOCAB: begin
              if (prefix_overflow || v64 > 64'(vocab_limit)) begin
                to_err = 1'b1; ecode = ntsd_pkg::E_VOCAB;
              end else begin
                emit = 1'b1; tok.kind = ntsd_pkg::K_VOCAB; tok.value = v64;
                complete = 1'b1;
              end
            end
            default: begin
              to_err = 1'b1; ecode = ntsd_pkg::E_TYPE;
            end
          endcase
        end
      end
      S_STRING: begin
        emit = 1'b1; tok.kind = ntsd_pkg::K_STRBYTE; tok.value = 64'(s_axis_tdata);
        complete = (payload_left <= 20'd1);
      end
      S_FLOAT: begin
        if (payload_left <= 20'd1) begin
          emit = 1'b1; tok.kind = ntsd_pkg::K_FLOAT;
          tok.value = {float_shift[55:0], s_axis_tdata};
          complete = 1'b1;
        end
      end
      default: ;
    endcase
    if (to_err) begin
      emit = 1'b1; tok = '0; tok.kind = ntsd_pkg::K_ERROR; tok.err = ecode;
      tok.depth = 6'(depth);
      complete = 1'b0; pushn = 1'b0; empty_list = 1'b0;
    end
  end

  // Stack command: push or count an element on a byte, one close step per owed end.
  always_comb begin
    cmd = '0;
    if (take) begin
      cmd.push = pushn;
      cmd.count = pushc;
      cmd.complete = complete;
    end else if (pend && out_free) begin
      cmd.complete = 1'b1;
    end
  end

  // List end token at the depth left after the close.
  always_comb begin
    end_tok = '0;
    end_tok.kind = ntsd_pkg::K_LISTEND;
    end_tok.depth = 6'(depth);
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= S_PREFIX;
      prefix_value <= '0;
      prefix_count <= '0;
      prefix_overflow <= 1'b0;
      payload_left <= '0;
      float_shift <= '0;
    end else begin
      if (take) begin
        if (to_err) begin
          mode <= S_ERROR;
        end else begin
          case (mode)
            S_PREFIX: begin
              if (!b_hi) begin
                if (s_axis_tdata != 8'd0) begin
                  if (shift >= 13'd64) begin
                    prefix_overflow <= 1'b1;
                  end else begin
                    if (shift > 13'd57 &&
                        ((s_axis_tdata >> (7'd64 - 7'(shift))) != 8'd0))
                      prefix_overflow <= 1'b1;
                    prefix_value <= prefix_value | (64'(s_axis_tdata) << shift[5:0]);
                  end
                end
                prefix_count <= prefix_count + 7'd1;
              end else begin
                prefix_value <= '0; prefix_count <= '0; prefix_overflow <= 1'b0;
                if (s_axis_tdata == ntsd_pkg::T_STRING && v64 != 64'd0) begin
                  mode <= S_STRING; payload_left <= v64[19:0];
                end else if (s_axis_tdata == ntsd_pkg::T_FLOAT) begin
                  mode <= S_FLOAT; payload_left <= 20'd8; float_shift <= '0;
                end
              end
            end
            S_STRING: begin
              payload_left <= payload_left - 20'd1;
              if (payload_left <= 20'd1) mode <= S_PREFIX;
            end
            S_FLOAT: begin
              payload_left <= payload_left - 20'd1;
              float_shift <= {float_shift[55:0], s_axis_tdata};
              if (payload_left <= 20'd1) mode <= S_PREFIX;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Output register: load the first token of a byte, then each owed list end.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      olast <= 1'b0;
      pend <= 1'b0;
      otok <= '0;
    end else if (out_free) begin
      if (take) begin
        otok <= tok;
        ovalid <= emit;
        olast <= !(empty_list || (complete && top_one));
        pend <= empty_list || (complete && top_one);
      end else if (pend) begin
        otok <= end_tok;
        ovalid <= 1'b1;
        olast <= !top_one;
        pend <= top_one;
      end else begin
        ovalid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tlast = olast;
  assign m_axis_tdata = {2'b00, otok.err, otok.depth, otok.ovf, otok.value, otok.kind};
endmodule

>>> design/ntsd_checker.sv
// Port-level checker for the token stream decoder, bound to the top level.
`include "nested_token_stream_decoder_assert.svh"
module ntsd_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic m_axis_tlast
);
  `NTSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `NTSD_ASSERT_IMP(a_kind_range, m_axis_tvalid, m_axis_tdata[3:0] <= ntsd_pkg::K_ERROR)
  `NTSD_ASSERT_IMP(a_err_last, m_axis_tvalid && m_axis_tdata[3:0] == ntsd_pkg::K_ERROR, m_axis_tlast)
  `NTSD_ASSERT_IMP(a_end_value, m_axis_tvalid && m_axis_tdata[3:0] == ntsd_pkg::K_LISTEND, m_axis_tdata[67:4] == 64'd0)
  `NTSD_ASSERT_IMP(a_in_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind nested_token_stream_decoder ntsd_checker u_ntsd_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
